// ----- src/bba_pkg.sv -----
// Package for the block bitmap allocator: field widths, operation, status and
// register codes, and the lowest-set-bit picker used by the scan.
// No dependencies.
package bba_pkg;

	localparam int FIELD_W    = 13;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 13;

	// Operation codes
	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	// Status codes
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_RANGE = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_MANAGED = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_OFFSET   = 1'b1;

	// Register reset values
	localparam logic [FIELD_W-1:0] BLOCKS_MANAGED_RST = 13'd4096;
	localparam logic               FIRST_OFFSET_RST   = 1'b1;

	typedef struct packed {
		logic       found;
		logic [4:0] bit_idx;
	} bit_pick_t;

	// Return the position of the lowest set bit of a word
	function automatic bit_pick_t lowest_set(input logic [31:0] v);
		bit_pick_t r;
		r = '0;
		for (int i = 31; i >= 0; i--) begin
			if (v[i]) begin
				r.found   = 1'b1;
				r.bit_idx = 5'(i);
			end
		end
		return r;
	endfunction

endpackage

// ----- src/bba_if.sv -----
// Request and response channel interfaces of the block bitmap allocator.
// Depends on bba_pkg.
interface bba_req_if import bba_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               func;
	logic [FIELD_W-1:0] block_number;

	modport source (output valid, func, block_number, input ready);
	modport sink (input valid, func, block_number, output ready);
endinterface

interface bba_rsp_if import bba_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] alloc_block;
	logic [1:0]         status;
	logic [FIELD_W-1:0] free_count;

	modport source (output valid, alloc_block, status, free_count, input ready);
	modport sink (input valid, alloc_block, status, free_count, output ready);
endinterface

// ----- src/bba_bitmap_mem.sv -----
// Bitmap word store: one write port, one registered read port, and a valid
// bit per word so that a word never written reads as all zeros after reset.
// No package dependencies.
module bba_bitmap_mem #(
	parameter int WORDS = 128,
	parameter int AW    = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);

	logic [31:0]      mem_q [WORDS];
	logic [WORDS-1:0] vld_q;
	logic [31:0]      rdata_q;
	logic             rvld_q;

	// Write the word array
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Register the read data
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	// Track written words; reset marks every word as clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			rvld_q <= vld_q[raddr];
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
		end
	end

	assign rdata = rvld_q ? rdata_q : 32'd0;

endmodule

// ----- src/block_bitmap_allocator.sv -----
// Block bitmap allocator top level: request/response channels, register
// write port, sequencer, bitmap store and free counter.
// Depends on bba_pkg, bba_req_if, bba_rsp_if and bba_bitmap_mem.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+----------------------------------
//  req     | in  | valid/ready          | func, block_number
//  rsp     | out | valid/ready          | alloc_block, status, free_count
//  cfg     | in  | cfg_we, no back-off  | cfg_index, cfg_wdata
//
// Allocate: one bitmap word is read per cycle through the single read port and
// checked the cycle after; the scan stops at the first free block, or at the
// last word with status FULL. Free: the word is read, then checked and the bit
// cleared if set; an out-of-range block number gets status RANGE without a read.
// Reset clears the bitmap at once through per-word valid bits; no sweep.
// One request is in work at a time; a finished response waits in the output
// register while the next request is taken.
module block_bitmap_allocator import bba_pkg::*; #(
	parameter int MAX_BLOCKS = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	bba_req_if.sink               req,
	bba_rsp_if.source             rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int WORDS   = (MAX_BLOCKS + 31) / 32;
	localparam int WORD_AW = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
	localparam int CW_A    = (WORD_AW + 6 > CNT_W + 1) ? WORD_AW + 6 : CNT_W + 1;
	localparam int CW      = (CW_A > FIELD_W + 1) ? CW_A : FIELD_W + 1;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_FREAD = 5'b00010,
		S_FCHK  = 5'b00100,
		S_SCAN  = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t               state_q, state_d;
	logic [FIELD_W-1:0]   bm_q;
	logic                 off_q;
	logic [CNT_W-1:0]     free_q;
	logic [WORD_AW-1:0]   w_q;
	logic [WORD_AW-1:0]   chk_w_s1;
	logic                 chk_pend_s1;
	logic [WORD_AW-1:0]   fword_q;
	logic [4:0]           fbit_q;
	logic [FIELD_W-1:0]   res_block_q;
	logic [1:0]           res_status_q;
	logic                 rsp_valid_q;
	logic [FIELD_W-1:0]   rsp_block_q;
	logic [1:0]           rsp_status_q;
	logic [FIELD_W-1:0]   rsp_count_q;

	logic [CW-1:0]        bm_c, n_c, off_c, num_c, fidx_c, base_c, diff_c, blk_c;
	logic                 range_bad;
	logic [31:0]          lim_mask, rdata, avail;
	bit_pick_t            pick;
	logic                 mem_we;
	logic [WORD_AW-1:0]   mem_waddr, raddr;
	logic [31:0]          mem_wdata;
	logic                 cnt_dec, cnt_inc, res_ld, load_out;
	logic [FIELD_W-1:0]   res_block_d;
	logic [1:0]           res_status_d;

	bba_bitmap_mem #(
		.WORDS(WORDS),
		.AW   (WORD_AW)
	) u_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Clamp the managed count to the bitmap size
	assign bm_c  = CW'(bm_q);
	assign n_c   = (bm_c > CW'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : bm_c;
	assign off_c = CW'(off_q);

	// Range check and bit position of a free request
	assign num_c     = CW'(req.block_number);
	assign fidx_c    = num_c - off_c;
	assign range_bad = (num_c < off_c) || (fidx_c >= n_c);

	// Mask off bits of the checked word at or past the managed count
	assign base_c = CW'({chk_w_s1, 5'd0});
	assign diff_c = n_c - base_c;
	always_comb begin
		priority if (n_c >= base_c + CW'(32)) begin
			lim_mask = 32'hFFFF_FFFF;
		end else if (n_c > base_c) begin
			lim_mask = (32'd1 << diff_c[4:0]) - 32'd1;
		end else begin
			lim_mask = 32'd0;
		end
	end

	assign avail = ~rdata & lim_mask;
	assign pick  = lowest_set(avail);
	assign blk_c = base_c + CW'(pick.bit_idx) + off_c;

	assign req.ready = (state_q == S_IDLE);

	// Sequencer
	always_comb begin
		state_d      = state_q;
		raddr        = fword_q;
		mem_we       = 1'b0;
		mem_waddr    = chk_w_s1;
		mem_wdata    = rdata;
		cnt_dec      = 1'b0;
		cnt_inc      = 1'b0;
		res_ld       = 1'b0;
		res_block_d  = '0;
		res_status_d = STATUS_OK;
		load_out     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					if (req.func == FUNC_ALLOC) begin
						state_d = S_SCAN;
					end else if (range_bad) begin
						res_ld       = 1'b1;
						res_status_d = STATUS_RANGE;
						state_d      = S_DONE;
					end else begin
						state_d = S_FREAD;
					end
				end
			end
			S_FREAD: begin
				state_d = S_FCHK;
			end
			S_FCHK: begin
				res_ld  = 1'b1;
				state_d = S_DONE;
				if (rdata[fbit_q]) begin
					mem_we    = 1'b1;
					mem_waddr = fword_q;
					mem_wdata = rdata & ~(32'd1 << fbit_q);
					cnt_inc   = 1'b1;
				end
			end
			S_SCAN: begin
				raddr = w_q;
				if (chk_pend_s1) begin
					if (pick.found) begin
						mem_we      = 1'b1;
						mem_wdata   = rdata | (32'd1 << pick.bit_idx);
						cnt_dec     = 1'b1;
						res_ld      = 1'b1;
						res_block_d = blk_c[FIELD_W-1:0];
						state_d     = S_DONE;
					end else if (chk_w_s1 == WORD_AW'(WORDS - 1)) begin
						res_ld       = 1'b1;
						res_status_d = STATUS_FULL;
						state_d      = S_DONE;
					end
				end
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Hold state, registers, counter and scan pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			bm_q        <= BLOCKS_MANAGED_RST;
			off_q       <= FIRST_OFFSET_RST;
			free_q      <= CNT_W'(MAX_BLOCKS);
			w_q         <= '0;
			chk_pend_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			chk_pend_s1 <= (state_q == S_SCAN);
			if (cfg_we) begin
				unique case (cfg_index)
					REG_BLOCKS_MANAGED: bm_q  <= cfg_wdata;
					REG_FIRST_OFFSET:   off_q <= cfg_wdata[0];
					default: ;
				endcase
			end
			if (cnt_dec && free_q != '0) begin
				free_q <= free_q - 1'b1;
			end
			if (cnt_inc && free_q != CNT_W'(MAX_BLOCKS)) begin
				free_q <= free_q + 1'b1;
			end
			// Advance the read pointer, stopping at the last word
			if (state_q == S_IDLE) begin
				w_q <= '0;
			end else if (state_q == S_SCAN && w_q != WORD_AW'(WORDS - 1)) begin
				w_q <= w_q + 1'b1;
			end
			// Load a new response, else drop a taken one
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		chk_w_s1 <= w_q;
		if (state_q == S_IDLE && req.valid) begin
			fword_q <= fidx_c[5 +: WORD_AW];
			fbit_q  <= fidx_c[4:0];
		end
		if (res_ld) begin
			res_block_q  <= res_block_d;
			res_status_q <= res_status_d;
		end
		if (load_out) begin
			rsp_block_q  <= res_block_q;
			rsp_status_q <= res_status_q;
			rsp_count_q  <= FIELD_W'(free_q);
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.alloc_block = rsp_block_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.free_count  = rsp_count_q;

endmodule

// ----- src/bba_checker.sv -----
// Port-level checks for the block bitmap allocator, bound to the top level.
// Depends on bba_pkg and block_bitmap_allocator.
module bba_props import bba_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input logic [FIELD_W-1:0] rsp_alloc_block,
	input logic [1:0]         rsp_status,
	input logic [FIELD_W-1:0] rsp_free_count
);

	// A stalled response keeps its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_alloc_block)
			&& $stable(rsp_status) && $stable(rsp_free_count))
		else $error("response changed while stalled");

	// Only the three defined status codes appear
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_status == STATUS_OK || rsp_status == STATUS_FULL
			|| rsp_status == STATUS_RANGE))
		else $error("undefined status code");

	// A failed request carries no block number
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != STATUS_OK |-> rsp_alloc_block == '0)
		else $error("block number on a failed request");

	// A taken request makes the block busy on the next cycle
	a_ready_after_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while busy");

endmodule

bind block_bitmap_allocator bba_props u_bba_props (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_alloc_block(rsp.alloc_block),
	.rsp_status     (rsp.status),
	.rsp_free_count (rsp.free_count)
);
